// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define BJF_ASSERT(lbl, ck, rstn, prop) \
    lbl: assert property (@(posedge ck) disable iff (!(rstn)) prop) \
        else $error("%m: assertion failed");

// Checked at every edge, reset included.
`define BJF_ASSERT_ALWAYS(lbl, ck, prop) \
    lbl: assert property (@(posedge ck) prop) \
        else $error("%m: assertion failed");

`endif

// ===== rtl/bjf_pkg.sv =====
// ----------------------------------------------------------------------------
// bjf_pkg
// Types and constants of the bounded job FIFO.
// ----------------------------------------------------------------------------
package bjf_pkg;

    localparam int JOB_W       = 32;
    localparam int QSIZE_W     = 5;
    localparam int CAP_W       = 5;
    localparam int DEPTH_DEF   = 16;
    localparam int TAG_W_DEF   = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    localparam logic CMD_ARRIVAL = 1'b0;
    localparam logic CMD_REQUEST = 1'b1;

    localparam logic KIND_NOTE = 1'b0;
    localparam logic KIND_JOB  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_NOTE,
        ST_JOB,
        ST_POP
    } bjf_state_t;

    typedef struct packed {
        logic               kind;
        logic [QSIZE_W-1:0] queue_size;
        logic               discard_flag;
        logic [JOB_W-1:0]   job_out;
        logic               last;
    } bjf_result_t;

endpackage

// ===== rtl/bjf_ram.sv =====
// ----------------------------------------------------------------------------
// bjf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bjf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rd_data_reg;

endmodule

// ===== rtl/bjf_ctrl.sv =====
// ----------------------------------------------------------------------------
// bjf_ctrl
// Queue pointers, fill count, server state and the result sequencer.
// ----------------------------------------------------------------------------
module bjf_ctrl #(
    parameter int DEPTH = bjf_pkg::DEPTH_DEF,
    parameter int SW    = bjf_pkg::JOB_W
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        command,
    input  logic [bjf_pkg::JOB_W-1:0]   job_tag,
    input  logic                        cfg_write,
    input  logic [bjf_pkg::CAP_W-1:0]   cfg_data,
    output logic                        ram_we,
    output logic [$clog2(DEPTH)-1:0]    ram_waddr,
    output logic [SW-1:0]               ram_wdata,
    output logic                        ram_re,
    output logic [$clog2(DEPTH)-1:0]    ram_raddr,
    input  logic [SW-1:0]               ram_rdata,
    output logic                        push,
    output bjf_pkg::bjf_result_t        res,
    input  logic                        push_ready
);

    import bjf_pkg::*;

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

    bjf_state_t        state_reg, state_next;
    logic [AW-1:0]     head_reg, head_next, head_inc;
    logic [AW-1:0]     tail_reg, tail_next, tail_inc;
    logic [CW-1:0]     fill_reg, fill_next, fill_new;
    logic              wait_reg, wait_next;
    logic              disc_reg, disc_next;
    logic              emit_reg, emit_next;
    logic [CAP_W-1:0]  cap_reg;
    logic [CMPW-1:0]   lim;
    logic              drop;
    logic              accept;

    // effective limit saturates at the store depth
    assign lim = (CMPW'(cap_reg) < CMPW'(DEPTH)) ? CMPW'(cap_reg) : CMPW'(DEPTH);
    assign drop = (CMPW'(fill_reg) >= lim);
    assign fill_new = drop ? fill_reg : fill_reg + CW'(1);

    assign head_inc = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
    assign tail_inc = (tail_reg == AW'(DEPTH - 1)) ? '0 : tail_reg + AW'(1);

    assign ram_waddr = tail_reg;
    assign ram_wdata = job_tag[SW-1:0];
    assign ram_raddr = head_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            fill_reg  <= '0;
            wait_reg  <= 1'b0;
            disc_reg  <= 1'b0;
            emit_reg  <= 1'b0;
            cap_reg   <= CAP_RESET;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            fill_reg  <= fill_next;
            wait_reg  <= wait_next;
            disc_reg  <= disc_next;
            emit_reg  <= emit_next;
            if (cfg_write)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        fill_next  = fill_reg;
        wait_next  = wait_reg;
        disc_next  = disc_reg;
        emit_next  = emit_reg;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        push       = 1'b0;
        in_stall   = (state_reg != ST_IDLE);
        accept     = 1'b0;
        res        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                accept = in_valid;
                if (accept && command == CMD_ARRIVAL)
                begin
                    ram_we     = !drop;
                    tail_next  = drop ? tail_reg : tail_inc;
                    fill_next  = fill_new;
                    disc_next  = drop;
                    emit_next  = wait_reg && (fill_new != '0);
                    state_next = ST_NOTE;
                end
                else if (accept)
                begin
                    wait_next = 1'b1;
                    if (fill_reg != '0)
                    begin
                        ram_re     = 1'b1;
                        state_next = ST_JOB;
                    end
                end
            end

            ST_NOTE:
            begin
                // head read runs here, after the tail write has landed
                ram_re           = emit_reg;
                push             = 1'b1;
                res.kind         = KIND_NOTE;
                res.queue_size   = QSIZE_W'(fill_reg);
                res.discard_flag = disc_reg;
                res.last         = !emit_reg;
                if (push_ready)
                begin
                    state_next = emit_reg ? ST_JOB : ST_IDLE;
                end
            end

            ST_JOB:
            begin
                push        = 1'b1;
                res.kind    = KIND_JOB;
                res.job_out = JOB_W'(ram_rdata);
                if (push_ready)
                begin
                    head_next  = head_inc;
                    fill_next  = fill_reg - CW'(1);
                    wait_next  = 1'b0;
                    state_next = ST_POP;
                end
            end

            ST_POP:
            begin
                push           = 1'b1;
                res.kind       = KIND_NOTE;
                res.queue_size = QSIZE_W'(fill_reg);
                res.last       = 1'b1;
                if (push_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/bjf_out.sv =====
// ----------------------------------------------------------------------------
// bjf_out
// One-entry output register between the sequencer and the result channel.
// ----------------------------------------------------------------------------
module bjf_out (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  bjf_pkg::bjf_result_t        res,
    output logic                        push_ready,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        kind,
    output logic [bjf_pkg::QSIZE_W-1:0] queue_size,
    output logic                        discard_flag,
    output logic [bjf_pkg::JOB_W-1:0]   job_out,
    output logic                        last
);

    import bjf_pkg::*;

    logic        valid_reg;
    bjf_result_t res_reg;

    assign push_ready = !valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (push_ready)
        begin
            valid_reg <= push;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ready && push)
        begin
            res_reg <= res;
        end
    end

    assign out_valid    = valid_reg;
    assign kind         = res_reg.kind;
    assign queue_size   = res_reg.queue_size;
    assign discard_flag = res_reg.discard_flag;
    assign job_out      = res_reg.job_out;
    assign last         = res_reg.last;

endmodule

// ===== rtl/bounded_job_fifo_pull.sv =====
// ----------------------------------------------------------------------------
// bounded_job_fifo_pull
// Bounded drop-tail job FIFO, pulled by one server.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): command 0 is a job arrival carrying
// job_tag, command 1 is a dequeue request from the server.
// Result channel (out_valid / out_stall): kind 0 is a size notification
// (queue_size, discard_flag), kind 1 a job handed over (job_out); last ends a request.
// An arrival gives a notification, and if the server was waiting, the job
// and a second notification. A request on a non-empty queue gives the head
// job and a notification; on an empty one it only marks the server waiting.
// The sequencer gives one result a cycle while the receiver does not stall,
// after the cycle that takes the request. The first result is registered
// in the state register and then in the output register before it is offered.
// A stall on the result side holds the output register and the sequencer;
// in_stall is high while a request is still being worked.
// cfg_write loads capacity_limit (cfg_data); write it only while idle.
// Reset empties the queue, marks the server busy, sets the limit to 16.
// ----------------------------------------------------------------------------
module bounded_job_fifo_pull #(
    parameter int DEPTH     = bjf_pkg::DEPTH_DEF,
    parameter int TAG_WIDTH = bjf_pkg::TAG_W_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        command,
    input  logic [bjf_pkg::JOB_W-1:0]   job_tag,
    input  logic                        cfg_write,
    input  logic [bjf_pkg::CAP_W-1:0]   cfg_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        kind,
    output logic [bjf_pkg::QSIZE_W-1:0] queue_size,
    output logic                        discard_flag,
    output logic [bjf_pkg::JOB_W-1:0]   job_out,
    output logic                        last
);

    import bjf_pkg::*;

    // stored tag width: only the low TAG_WIDTH bits are kept, and never
    // more than the result field can show
    localparam int SW = (TAG_WIDTH < JOB_W) ? TAG_WIDTH : JOB_W;
    localparam int AW = $clog2(DEPTH);

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [SW-1:0] ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [SW-1:0] ram_rdata;

    logic          push;
    logic          push_ready;
    bjf_result_t   res;

    // job store
    bjf_ram #(
        .WIDTH (SW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // pointers, counts and the result sequencer
    bjf_ctrl #(
        .DEPTH (DEPTH),
        .SW    (SW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .job_tag    (job_tag),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .push       (push),
        .res        (res),
        .push_ready (push_ready)
    );

    // output register decouples the result receiver
    bjf_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .res          (res),
        .push_ready   (push_ready),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .queue_size   (queue_size),
        .discard_flag (discard_flag),
        .job_out      (job_out),
        .last         (last)
    );

endmodule

// ===== rtl/bjf_checker.sv =====
// ----------------------------------------------------------------------------
// bjf_checker
// Port-level checks of the bounded job FIFO, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bjf_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic                        command,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic                        kind,
    input logic [bjf_pkg::QSIZE_W-1:0] queue_size,
    input logic                        discard_flag,
    input logic [bjf_pkg::JOB_W-1:0]   job_out,
    input logic                        last
);

    import bjf_pkg::*;

    logic out_take;
    logic job_clean;
    logic note_last;
    logic arrival_take;

    assign out_take     = out_valid && !out_stall;
    assign job_clean    = (queue_size == '0) && !discard_flag && !last;
    assign note_last    = out_valid && (kind == KIND_NOTE) && last;
    assign arrival_take = in_valid && !in_stall && (command == CMD_ARRIVAL);

    // an edge seen in reset leaves nothing offered at the next one
    `BJF_ASSERT_ALWAYS(a_rst_quiet, clk, !rst_n |=> !out_valid)

    // a handed-over job is never the last result and carries no size
    `BJF_ASSERT(a_job_fields, clk, rst_n, out_valid && kind == KIND_JOB |-> job_clean)

    // notifications carry no job
    `BJF_ASSERT(a_note_fields, clk, rst_n, out_valid && kind == KIND_NOTE |-> job_out == '0)

    // a taken job is followed at once by the closing size notification
    `BJF_ASSERT(a_job_then_note, clk, rst_n, out_take && kind == KIND_JOB |=> note_last)

    // an arrival always produces a result, so the input is held off next cycle
    `BJF_ASSERT(a_arrival_busy, clk, rst_n, arrival_take |=> in_stall)

endmodule

bind bounded_job_fifo_pull bjf_checker u_bjf_checker (.*);
